>>> hw/rtl/jtq_pkg.sv
// shared types and constants of the joystick and touch event qualifier
package jtq_pkg;

	// number of touch readings carried by one poll
	localparam int FIELD_PADS = 4;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CENTER_X        = 3'd0,
		CFG_CENTER_Y        = 3'd1,
		CFG_DEAD_ZONE       = 3'd2,
		CFG_TOUCH_THRESHOLD = 3'd3,
		CFG_FIRST_REPEAT_MS = 3'd4,
		CFG_REPEAT_MS       = 3'd5,
		CFG_TOUCH_LOCKOUT   = 3'd6
	} cfg_reg_t;

	// joystick directions, values match their event codes
	typedef enum logic [2:0] {
		DIR_NONE  = 3'd0,
		DIR_UP    = 3'd1,
		DIR_DOWN  = 3'd2,
		DIR_LEFT  = 3'd3,
		DIR_RIGHT = 3'd4
	} dir_t;

	localparam logic [3:0] EV_NONE     = 4'd0;
	localparam logic [3:0] EV_PAD_BASE = 4'd5;
	localparam logic [3:0] EV_MAX      = 4'd8;

	// register reset values
	localparam logic [11:0] RST_CENTER_X        = 12'd2048;
	localparam logic [11:0] RST_CENTER_Y        = 12'd2048;
	localparam logic [11:0] RST_DEAD_ZONE       = 12'd0;
	localparam logic [15:0] RST_TOUCH_THRESHOLD = 16'd0;
	localparam logic [15:0] RST_FIRST_REPEAT_MS = 16'd350;
	localparam logic [15:0] RST_REPEAT_MS       = 16'd130;
	localparam logic [15:0] RST_TOUCH_LOCKOUT   = 16'd250;

	typedef struct packed {
		logic [11:0] center_x;
		logic [11:0] center_y;
		logic [11:0] dead_zone;
		logic [15:0] touch_threshold;
		logic [15:0] first_repeat_ms;
		logic [15:0] repeat_ms;
		logic [15:0] touch_lockout_ms;
	} cfg_t;

endpackage

>>> hw/rtl/jtq_joy.sv
// joystick direction classifier with held-direction auto-repeat state
module jtq_joy (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           step,
	input  logic [31:0]    now_ms,
	input  logic [11:0]    joy_x,
	input  logic [11:0]    joy_y,
	input  jtq_pkg::cfg_t  cfg,
	output logic           fire,
	output jtq_pkg::dir_t  dir
);

	jtq_pkg::dir_t held_q;
	logic [31:0] next_repeat_q;

	logic signed [12:0] dx, dy;
	logic [12:0] ax, ay, dz;
	jtq_pkg::dir_t d;
	logic [31:0] diff;
	logic fresh, due;

	always_comb begin
		dx = $signed({1'b0, joy_x}) - $signed({1'b0, cfg.center_x});
		dy = $signed({1'b0, joy_y}) - $signed({1'b0, cfg.center_y});
		ax = dx[12] ? 13'(-dx) : 13'(dx);
		ay = dy[12] ? 13'(-dy) : 13'(dy);
		dz = {1'b0, cfg.dead_zone};
		// vertical wins only when strictly larger, ties go horizontal
		if (ay > ax && ay > dz) begin
			d = (!dy[12] && dy != '0) ? jtq_pkg::DIR_DOWN : jtq_pkg::DIR_UP;
		end else if (ax > dz) begin
			d = (!dx[12] && dx != '0) ? jtq_pkg::DIR_RIGHT : jtq_pkg::DIR_LEFT;
		end else begin
			d = jtq_pkg::DIR_NONE;
		end
		diff = now_ms - next_repeat_q;
		due = !diff[31];
		fresh = d != held_q;
		fire = d != jtq_pkg::DIR_NONE && (fresh || due);
		dir = d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= jtq_pkg::DIR_NONE;
			next_repeat_q <= '0;
		end else if (step) begin
			if (d == jtq_pkg::DIR_NONE) begin
				held_q <= jtq_pkg::DIR_NONE;
			end else if (fire) begin
				held_q <= d;
				next_repeat_q <= now_ms +
					{16'b0, fresh ? cfg.first_repeat_ms : cfg.repeat_ms};
			end
		end
	end

endmodule

>>> hw/rtl/jtq_pad_scan.sv
// touch pad priority scan with per-pad lockout timestamps
module jtq_pad_scan #(
	parameter int NPADS = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  logic [31:0] now_ms,
	input  logic [jtq_pkg::FIELD_PADS-1:0][15:0] reading,
	input  jtq_pkg::cfg_t cfg,
	output logic [3:0]  code
);

	logic [31:0] last_q [NPADS];
	logic [NPADS-1:0] grant;
	logic [31:0] age;
	logic taken;

	always_comb begin
		grant = '0;
		code = jtq_pkg::EV_NONE;
		taken = 1'b0;
		age = '0;
		for (int i = 0; i < NPADS; i++) begin
			age = now_ms - last_q[i];
			if (!taken && reading[i] < cfg.touch_threshold &&
				age >= {16'b0, cfg.touch_lockout_ms}) begin
				grant[i] = 1'b1;
				code = jtq_pkg::EV_PAD_BASE + 4'(i);
				taken = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NPADS; i++) begin
				last_q[i] <= '0;
			end
		end else if (step) begin
			for (int i = 0; i < NPADS; i++) begin
				if (grant[i]) begin
					last_q[i] <= now_ms;
				end
			end
		end
	end

endmodule

>>> hw/rtl/joystick_touch_event_qualifier.sv
// top level: poll register, event logic, result register and config registers
// a transferred poll is held in the input register, then loaded into the result register,
//   which shows its event code on the output
// throughput: one poll per cycle while the output is not stalled; the joystick repeat state and pad
//   timestamps update in the same cycle the poll leaves the input register
// reset (arst_n low): pipeline empty, no direction held, repeat time zero,
//   every pad timestamp zero, config registers at their reset values
module joystick_touch_event_qualifier #(
	parameter int PAD_COUNT = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	// poll channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] now_ms,
	input  logic [11:0] joy_x,
	input  logic [11:0] joy_y,
	input  logic [15:0] pad_select,
	input  logic [15:0] pad_back,
	input  logic [15:0] pad_enter,
	input  logic [15:0] pad_menu,
	// event channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  event_code,
	// configuration write port
	input  logic        cfg_we,
	input  logic [jtq_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [jtq_pkg::CFG_DATA_W-1:0] cfg_data
);

	// only pads with a reading field take part in the scan
	localparam int NPADS = (PAD_COUNT < jtq_pkg::FIELD_PADS) ?
		PAD_COUNT : jtq_pkg::FIELD_PADS;

	jtq_pkg::cfg_t cfg_q;

	// input register
	logic        valid_s1;
	logic [31:0] now_s1;
	logic [11:0] joy_x_s1, joy_y_s1;
	logic [jtq_pkg::FIELD_PADS-1:0][15:0] pad_s1;

	// result register
	logic       out_valid_q;
	logic [3:0] event_q;

	logic adv, step;
	logic joy_fire;
	jtq_pkg::dir_t joy_dir;
	logic [3:0] pad_code;
	logic [3:0] ev;

	// the poll moves on when the result register is empty or being drained
	assign adv = !out_valid_q || !out_stall;
	assign step = valid_s1 && adv;
	assign in_stall = valid_s1 && !adv;

	// configuration registers, unused index ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.center_x <= jtq_pkg::RST_CENTER_X;
			cfg_q.center_y <= jtq_pkg::RST_CENTER_Y;
			cfg_q.dead_zone <= jtq_pkg::RST_DEAD_ZONE;
			cfg_q.touch_threshold <= jtq_pkg::RST_TOUCH_THRESHOLD;
			cfg_q.first_repeat_ms <= jtq_pkg::RST_FIRST_REPEAT_MS;
			cfg_q.repeat_ms <= jtq_pkg::RST_REPEAT_MS;
			cfg_q.touch_lockout_ms <= jtq_pkg::RST_TOUCH_LOCKOUT;
		end else if (cfg_we) begin
			unique case (jtq_pkg::cfg_reg_t'(cfg_index))
				jtq_pkg::CFG_CENTER_X:        cfg_q.center_x <= cfg_data[11:0];
				jtq_pkg::CFG_CENTER_Y:        cfg_q.center_y <= cfg_data[11:0];
				jtq_pkg::CFG_DEAD_ZONE:       cfg_q.dead_zone <= cfg_data[11:0];
				jtq_pkg::CFG_TOUCH_THRESHOLD: cfg_q.touch_threshold <= cfg_data;
				jtq_pkg::CFG_FIRST_REPEAT_MS: cfg_q.first_repeat_ms <= cfg_data;
				jtq_pkg::CFG_REPEAT_MS:       cfg_q.repeat_ms <= cfg_data;
				jtq_pkg::CFG_TOUCH_LOCKOUT:   cfg_q.touch_lockout_ms <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	// input register payload, loads on every transfer
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			now_s1 <= now_ms;
			joy_x_s1 <= joy_x;
			joy_y_s1 <= joy_y;
			pad_s1 <= {pad_menu, pad_enter, pad_back, pad_select};
		end
	end

	jtq_joy u_joy (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.now_ms (now_s1),
		.joy_x  (joy_x_s1),
		.joy_y  (joy_y_s1),
		.cfg    (cfg_q),
		.fire   (joy_fire),
		.dir    (joy_dir)
	);

	// pads are scanned only when the joystick gives nothing
	jtq_pad_scan #(
		.NPADS (NPADS)
	) u_pads (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step && !joy_fire),
		.now_ms  (now_s1),
		.reading (pad_s1),
		.cfg     (cfg_q),
		.code    (pad_code)
	);

	assign ev = joy_fire ? {1'b0, joy_dir} : pad_code;

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			event_q <= ev;
		end
	end

	assign out_valid = out_valid_q;
	assign event_code = event_q;

endmodule

>>> hw/rtl/jtq_checker.sv
// port-level checker for the joystick and touch event qualifier, with bind
module jtq_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [3:0] event_code
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(event_code))
		else $error("stalled event changed");

	// event codes stay in range
	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> event_code <= jtq_pkg::EV_MAX)
		else $error("event code out of range");

	// input back-pressure only comes from a full, stalled output
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output stall");

	// an accepted poll moves from the input register into the result register when the output is not stalled
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) ##1 !out_stall |=> out_valid)
		else $error("accepted poll did not reach the output");

endmodule

bind joystick_touch_event_qualifier jtq_checker u_jtq_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.event_code (event_code)
);

>>> tb/sv/jtq_tb_pkg.sv
// event predictor and checker class for the joystick and touch event qualifier bench
`timescale 1ns / 1ps
package jtq_tb_pkg;
	import jtq_pkg::*;

	// one poll as driven on the input ports, pad[0] is select
	typedef struct packed {
		logic [31:0]                 now_ms;
		logic [11:0]                 joy_x;
		logic [11:0]                 joy_y;
		logic [FIELD_PADS-1:0][15:0] pad;
	} poll_t;

	class jtq_event_predictor;
		cfg_t        regs;
		dir_t        held_dir;
		logic [31:0] next_repeat_ms;
		logic [31:0] pad_stamp [FIELD_PADS];
		logic [3:0]  expected_codes [$];
		int unsigned fail_count;

		function new();
			int i;
			regs.center_x = RST_CENTER_X;
			regs.center_y = RST_CENTER_Y;
			regs.dead_zone = RST_DEAD_ZONE;
			regs.touch_threshold = RST_TOUCH_THRESHOLD;
			regs.first_repeat_ms = RST_FIRST_REPEAT_MS;
			regs.repeat_ms = RST_REPEAT_MS;
			regs.touch_lockout_ms = RST_TOUCH_LOCKOUT;
			held_dir = DIR_NONE;
			next_repeat_ms = '0;
			for (i = 0; i < FIELD_PADS; i++)
				pad_stamp[i] = '0;
			fail_count = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				CFG_CENTER_X:        regs.center_x = data[11:0];
				CFG_CENTER_Y:        regs.center_y = data[11:0];
				CFG_DEAD_ZONE:       regs.dead_zone = data[11:0];
				CFG_TOUCH_THRESHOLD: regs.touch_threshold = data;
				CFG_FIRST_REPEAT_MS: regs.first_repeat_ms = data;
				CFG_REPEAT_MS:       regs.repeat_ms = data;
				CFG_TOUCH_LOCKOUT:   regs.touch_lockout_ms = data;
				default: ;
			endcase
		endfunction

		// vertical wins only when strictly larger, ties go horizontal
		function dir_t classify(logic [11:0] jx, logic [11:0] jy);
			int dx, dy, ax, ay, dz;
			dx = int'(jx) - int'(regs.center_x);
			dy = int'(jy) - int'(regs.center_y);
			ax = (dx < 0) ? -dx : dx;
			ay = (dy < 0) ? -dy : dy;
			dz = int'(regs.dead_zone);
			if (ay > ax && ay > dz)
				return (dy > 0) ? DIR_DOWN : DIR_UP;
			if (ax > dz)
				return (dx > 0) ? DIR_RIGHT : DIR_LEFT;
			return DIR_NONE;
		endfunction

		function void note_poll(poll_t p);
			dir_t        d;
			logic [31:0] diff;
			logic [3:0]  code;
			int          i;
			d = classify(p.joy_x, p.joy_y);
			code = EV_NONE;
			if (d == DIR_NONE) begin
				held_dir = DIR_NONE;
			end else begin
				diff = p.now_ms - next_repeat_ms;
				if (d != held_dir || !diff[31]) begin
					next_repeat_ms = p.now_ms + ((d != held_dir) ?
						{16'd0, regs.first_repeat_ms} : {16'd0, regs.repeat_ms});
					held_dir = d;
					code = {1'b0, d};
				end
			end
			for (i = 0; i < FIELD_PADS && code == EV_NONE; i++) begin
				if (p.pad[i] < regs.touch_threshold &&
				    (p.now_ms - pad_stamp[i]) >= {16'd0, regs.touch_lockout_ms}) begin
					pad_stamp[i] = p.now_ms;
					code = EV_PAD_BASE + 4'(i);
				end
			end
			expected_codes.push_back(code);
		endfunction

		function void flag(string what, logic [3:0] want, logic [3:0] got);
			fail_count++;
			if (fail_count <= 10)
				$display("%0t: %s: expected %0d, got %0d", $time, what, want, got);
		endfunction

		function void check_event(logic [3:0] code);
			logic [3:0] want;
			if (expected_codes.size() == 0) begin
				flag("event with no poll waiting", 4'bx, code);
				return;
			end
			want = expected_codes.pop_front();
			if (code !== want)
				flag("event_code mismatch", want, code);
		endfunction

		function int pending();
			return expected_codes.size();
		endfunction
	endclass

endpackage

>>> tb/sv/joystick_touch_event_qualifier_tb.sv
// self-checking bench of the joystick and touch event qualifier: directed polls, then random phases
`timescale 1ns / 1ps
module joystick_touch_event_qualifier_tb;
	import jtq_pkg::*;
	import jtq_tb_pkg::*;

	// an index past the last register, the block must ignore writes to it
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 3'd7;
	localparam int PHASES = 8;
	localparam int POLLS_PER_PHASE = 200;
	localparam int HOLD_CYCLES = 120;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [31:0] now_ms = '0;
	logic [11:0] joy_x = '0;
	logic [11:0] joy_y = '0;
	logic [15:0] pad_select = '0;
	logic [15:0] pad_back = '0;
	logic [15:0] pad_enter = '0;
	logic [15:0] pad_menu = '0;
	logic        out_valid;
	logic        out_stall = 1'b1;
	logic [3:0]  event_code;
	logic        cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	jtq_event_predictor predictor;

	// idle rates in percent per cycle, changed only at clock edges
	int   tx_idle_pct = 30;
	int   rx_stall_pct = 51;
	int   tx_burst = 0;
	int   rx_burst = 0;
	logic hold_rx = 1'b0;

	// stimulus state: poll clock in ms, current stick position and how long it stays
	cfg_t        cur_cfg;
	logic [31:0] clock_ms = '0;
	logic [11:0] stick_x = 12'd2048;
	logic [11:0] stick_y = 12'd2048;
	int          stick_left = 0;

	joystick_touch_event_qualifier DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.now_ms     (now_ms),
		.joy_x      (joy_x),
		.joy_y      (joy_y),
		.pad_select (pad_select),
		.pad_back   (pad_back),
		.pad_enter  (pad_enter),
		.pad_menu   (pad_menu),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.event_code (event_code),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// event side: values read right after the edge are the ones the edge saw
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			predictor.check_event(event_code);
		if (hold_rx) begin
			out_stall <= 1'b1;
		end else if (rx_burst > 0) begin
			// stretch with the receiver always ready
			rx_burst--;
			out_stall <= 1'b0;
		end else if ($urandom_range(0, 99) < 2) begin
			rx_burst = $urandom_range(10, 40);
			out_stall <= 1'b0;
		end else begin
			out_stall <= ($urandom_range(0, 99) < rx_stall_pct);
		end
	end

	// run ends here if the block hangs
	initial begin
		#2_000_000;
		$display("FAILURE");
		$finish;
	end

	function automatic logic [11:0] clamp12(int v);
		if (v < 0)
			return 12'd0;
		if (v > 4095)
			return 12'd4095;
		return v[11:0];
	endfunction

	// offer one poll and return at the edge where the transfer happens;
	// valid stays high so the next poll can follow without a gap
	task automatic send_poll(input poll_t p);
		if (tx_burst > 0) begin
			tx_burst--;
		end else if ($urandom_range(0, 99) < 3) begin
			tx_burst = $urandom_range(10, 40);
		end else begin
			while ($urandom_range(0, 99) < tx_idle_pct) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid <= 1'b1;
		now_ms <= p.now_ms;
		joy_x <= p.joy_x;
		joy_y <= p.joy_y;
		pad_select <= p.pad[0];
		pad_back <= p.pad[1];
		pad_enter <= p.pad[2];
		pad_menu <= p.pad[3];
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predictor.note_poll(p);
	endtask

	task automatic send_directed(input logic [31:0] t, input logic [11:0] jx,
	                             input logic [11:0] jy, input logic [15:0] ps,
	                             input logic [15:0] pb, input logic [15:0] pe,
	                             input logic [15:0] pm);
		poll_t p;
		p.now_ms = t;
		p.joy_x = jx;
		p.joy_y = jy;
		p.pad[0] = ps;
		p.pad[1] = pb;
		p.pad[2] = pe;
		p.pad[3] = pm;
		send_poll(p);
		clock_ms = t;
	endtask

	// drop valid and wait until every event is back, then a margin
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (predictor.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		predictor.write_reg(idx, data);
	endtask

	// writes every register, plus junk to the spare index, only while drained
	task automatic apply_config(input cfg_t c);
		write_reg(CFG_CENTER_X, {4'hF, c.center_x});
		write_reg(CFG_CENTER_Y, {4'hF, c.center_y});
		write_reg(CFG_DEAD_ZONE, {4'hF, c.dead_zone});
		write_reg(CFG_SPARE_IDX, 16'($urandom()));
		write_reg(CFG_TOUCH_THRESHOLD, c.touch_threshold);
		write_reg(CFG_FIRST_REPEAT_MS, c.first_repeat_ms);
		write_reg(CFG_REPEAT_MS, c.repeat_ms);
		write_reg(CFG_TOUCH_LOCKOUT, c.touch_lockout_ms);
		cfg_we <= 1'b0;
		@(posedge clk);
		cur_cfg = c;
	endtask

	// phase 1 all low but the touch threshold at its top, phase 2 all high, the rest random around mid-scale
	function automatic cfg_t pick_config(int ph);
		cfg_t c;
		if (ph == 1) begin
			c = '0;
			c.touch_threshold = 16'hFFFF;
		end else if (ph == 2) begin
			c = '1;
		end else begin
			c.center_x = 12'($urandom_range(1024, 3072));
			c.center_y = 12'($urandom_range(1024, 3072));
			c.dead_zone = 12'($urandom_range(0, 600));
			c.touch_threshold = 16'($urandom());
			c.first_repeat_ms = 16'($urandom_range(0, 800));
			c.repeat_ms = 16'($urandom_range(0, 400));
			c.touch_lockout_ms = 16'($urandom_range(0, 800));
		end
		return c;
	endfunction

	function automatic poll_t next_poll();
		poll_t p;
		int    horizon, r, m, o, sx, sy, cx, cy, dz, thr, i;
		// time steps scale with the longest configured delay so repeats stay reachable
		horizon = int'(cur_cfg.first_repeat_ms);
		if (int'(cur_cfg.repeat_ms) > horizon)
			horizon = int'(cur_cfg.repeat_ms);
		if (int'(cur_cfg.touch_lockout_ms) > horizon)
			horizon = int'(cur_cfg.touch_lockout_ms);
		horizon = horizon / 2 + 20;
		r = $urandom_range(0, 99);
		if (r < 2)
			clock_ms = $urandom();
		else if (r < 3)
			clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 3 * horizon);
		else
			clock_ms = clock_ms + $urandom_range(0, horizon);
		p.now_ms = clock_ms;

		// the stick holds one position for a few polls so repeats get exercised
		if (stick_left == 0) begin
			stick_left = $urandom_range(1, 12);
			cx = int'(cur_cfg.center_x);
			cy = int'(cur_cfg.center_y);
			dz = int'(cur_cfg.dead_zone);
			sx = $urandom_range(0, 1) ? 1 : -1;
			sy = $urandom_range(0, 1) ? 1 : -1;
			case ($urandom_range(0, 9))
				0, 1: begin
					// inside the dead zone, boundary included
					stick_x = clamp12(cx + int'($urandom_range(0, 2 * dz)) - dz);
					stick_y = clamp12(cy + int'($urandom_range(0, 2 * dz)) - dz);
				end
				2: begin
					stick_x = 12'($urandom());
					stick_y = 12'($urandom());
				end
				3: begin
					// equal magnitudes on both axes
					m = $urandom_range(0, 600);
					stick_x = clamp12(cx + sx * m);
					stick_y = clamp12(cy + sy * m);
				end
				default: begin
					m = dz + 1 + int'($urandom_range(0, 400));
					o = $urandom_range(0, m - 1);
					if ($urandom_range(0, 1)) begin
						stick_x = clamp12(cx + sx * m);
						stick_y = clamp12(cy + sy * o);
					end else begin
						stick_x = clamp12(cx + sx * o);
						stick_y = clamp12(cy + sy * m);
					end
				end
			endcase
		end
		stick_left--;
		p.joy_x = stick_x;
		p.joy_y = stick_y;

		// pad readings around the press threshold, both sides of it
		thr = int'(cur_cfg.touch_threshold);
		for (i = 0; i < FIELD_PADS; i++) begin
			case ($urandom_range(0, 4))
				0: p.pad[i] = 16'($urandom());
				1: p.pad[i] = (thr == 0) ? 16'd0 : 16'(thr - 1);
				2: p.pad[i] = 16'(thr);
				3: p.pad[i] = 16'($urandom_range(0, thr));
				default: p.pad[i] = 16'hFFFF;
			endcase
		end
		return p;
	endfunction

	initial begin
		cfg_t dcfg;
		int   ph, n;
		predictor = new();
		cur_cfg = predictor.regs;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values: centered stick, threshold zero, nothing fires
		send_directed(32'd0, 12'd2048, 12'd2048, 16'd0, 16'd0, 16'd0, 16'd0);
		wait_drained();
		dcfg = predictor.regs;
		dcfg.dead_zone = 12'd100;
		dcfg.touch_threshold = 16'd1000;
		apply_config(dcfg);

		// pads stay locked after reset until the lockout time is reached
		send_directed(32'd10, 12'd2048, 12'd2048, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_directed(32'd249, 12'd2048, 12'd2048, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		// scan order select, back, enter, menu with per-pad lockout
		send_directed(32'd250, 12'd2048, 12'd2048, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF);
		send_directed(32'd251, 12'd2048, 12'd2048, 16'd0, 16'd999, 16'hFFFF, 16'hFFFF);
		send_directed(32'd252, 12'd2048, 12'd2048, 16'hFFFF, 16'd0, 16'd0, 16'hFFFF);
		send_directed(32'd253, 12'd2048, 12'd2048, 16'd0, 16'd0, 16'd0, 16'd0);
		// reading equal to the threshold is no press
		send_directed(32'd254, 12'd2048, 12'd2048, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd1000);
		// joystick wins over pads, then first delay and repeat interval
		send_directed(32'd300, 12'd2048, 12'd0, 16'd0, 16'd0, 16'd0, 16'd0);
		send_directed(32'd301, 12'd2048, 12'd0, 16'd0, 16'd0, 16'd0, 16'd0);
		send_directed(32'd650, 12'd2048, 12'd0, 16'd0, 16'd0, 16'd0, 16'd0);
		send_directed(32'd779, 12'd2048, 12'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_directed(32'd780, 12'd2048, 12'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		// every direction, tie goes horizontal
		send_directed(32'd781, 12'd2048, 12'd4095, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_directed(32'd782, 12'd2248, 12'd2248, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_directed(32'd783, 12'd0, 12'd2048, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		// offset equal to the dead zone is centered, one more is a direction
		send_directed(32'd784, 12'd2148, 12'd2048, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_directed(32'd785, 12'd2149, 12'd2048, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		// centered stick clears the held direction and lets the pads through
		send_directed(32'd786, 12'd2048, 12'd1948, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		// time wraps: repeat due across zero, pad lockout across zero
		send_directed(32'hFFFF_FFFF, 12'd4095, 12'd4095, 16'd0, 16'd0, 16'd0, 16'd0);
		send_directed(32'd5, 12'd4095, 12'd4095, 16'd0, 16'd0, 16'd0, 16'd0);
		send_directed(32'd349, 12'd4095, 12'd4095, 16'd0, 16'd0, 16'd0, 16'd0);
		send_directed(32'd350, 12'd0, 12'd0, 16'd0, 16'd0, 16'd0, 16'd0);

		for (ph = 1; ph <= PHASES; ph++) begin
			wait_drained();
			// sender 30 / receiver 51, then swapped, then no idling at all
			if (ph <= 3) begin
				tx_idle_pct <= 30;
				rx_stall_pct <= 51;
			end else if (ph <= 6) begin
				tx_idle_pct <= 51;
				rx_stall_pct <= 30;
			end else begin
				tx_idle_pct <= 0;
				rx_stall_pct <= 0;
			end
			apply_config(pick_config(ph));
			// receiver holds off for a long stretch while polls keep coming
			if (ph == 7) begin
				fork
					begin
						hold_rx <= 1'b1;
						repeat (HOLD_CYCLES) @(posedge clk);
						hold_rx <= 1'b0;
					end
				join_none
			end
			for (n = 0; n < POLLS_PER_PHASE; n++) begin
				// sender pauses until every event is back
				if (ph == 4 && n == POLLS_PER_PHASE / 2)
					wait_drained();
				send_poll(next_poll());
			end
		end

		wait_drained();
		repeat (8) @(posedge clk);
		if (predictor.fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

>>> joystick_touch_event_qualifier.f
hw/rtl/jtq_pkg.sv
hw/rtl/jtq_joy.sv
hw/rtl/jtq_pad_scan.sv
hw/rtl/joystick_touch_event_qualifier.sv
hw/rtl/jtq_checker.sv
tb/sv/jtq_tb_pkg.sv
tb/sv/joystick_touch_event_qualifier_tb.sv
